[sv/relay_link_stop_and_wait_macros.svh]
// Assertion macros for the relay link block.
`ifndef RELAY_LINK_STOP_AND_WAIT_MACROS_SVH
`define RELAY_LINK_STOP_AND_WAIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset
`define RLSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define RLSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RLSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RLSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/rlsw_pkg.sv]
// Types, codes and helpers shared by the relay link block.
package rlsw_pkg;

  localparam int unsigned ADDR_W       = 8;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned RING_SLOTS_DEF = 8;

  // Event codes
  localparam logic [2:0] FUNC_RTS  = 3'd0;
  localparam logic [2:0] FUNC_DATA = 3'd1;
  localparam logic [2:0] FUNC_SEND = 3'd2;
  localparam logic [2:0] FUNC_ACK  = 3'd3;
  localparam logic [2:0] FUNC_DONE = 3'd4;

  // Header types
  localparam logic [1:0] FT_RTS = 2'd0;
  localparam logic [1:0] FT_CTS = 2'd1;
  localparam logic [1:0] FT_ACK = 2'd2;
  localparam logic [1:0] FT_PAY = 2'd3;
  localparam logic [1:0] FT_NONE = 2'd0;

  // Result kinds
  localparam logic [1:0] RK_CTS  = 2'd0;
  localparam logic [1:0] RK_ACK  = 2'd1;
  localparam logic [1:0] RK_DESC = 2'd2;
  localparam logic [1:0] RK_REL  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_B = 2'd2;

  typedef struct packed {
    logic [2:0]        func;
    logic [1:0]        frame_type;
    logic [ADDR_W-1:0] frame_dest;
    logic [ADDR_W-1:0] frame_src;
    logic              frame_seq;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [1:0]        hdr_type;
    logic [ADDR_W-1:0] hdr_dest;
    logic [ADDR_W-1:0] hdr_src;
    logic              busy_flag;
    logic              seq_bit;
    logic [SLOT_W-1:0] slot;
    logic              stored;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] node_address;
    logic [ADDR_W-1:0] neighbor_a;
    logic [ADDR_W-1:0] neighbor_b;
  } cfg_t;

  // Ring request from the decoder
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [ADDR_W-1:0] dest;
    logic              seq;
  } ring_cmd_t;

  // Ring status toward the decoder; head is the entry at the read pointer
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] head_dest;
    logic              head_seq;
  } ring_stat_t;

  // Slot field of a result: low bits of a pointer widened to a byte
  function automatic logic [SLOT_W-1:0] slot_field(input logic [ADDR_W-1:0] ptr);
    return ptr[SLOT_W-1:0];
  endfunction

endpackage

[sv/rlsw_cfg.sv]
// Configuration registers: node address and the two neighbor addresses.
module rlsw_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rlsw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rlsw_pkg::ADDR_W-1:0]    cfg_data_i,
  output rlsw_pkg::cfg_t                 cfg_o
);
  import rlsw_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register write; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NODE_ADDR:  cfg_q.node_address <= cfg_data_i;
        CFG_NEIGHBOR_A: cfg_q.neighbor_a   <= cfg_data_i;
        CFG_NEIGHBOR_B: cfg_q.neighbor_b   <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

[sv/rlsw_ring.sv]
// Descriptor ring: slot memory, write and read pointers, full flag, head register.
module rlsw_ring #(
  parameter int unsigned RingSlots = rlsw_pkg::RING_SLOTS_DEF,
  localparam int unsigned PtrW     = (RingSlots > 1) ? $clog2(RingSlots) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rlsw_pkg::ring_cmd_t   cmd_i,
  output rlsw_pkg::ring_stat_t  stat_o,
  output logic [PtrW-1:0]       wr_ptr_o,
  output logic [PtrW-1:0]       rd_ptr_o
);
  import rlsw_pkg::*;

  localparam logic [PtrW-1:0] LastSlot = PtrW'(RingSlots - 1);

  logic [ADDR_W:0]   mem_q [RingSlots];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic              full_q, full_d;
  logic [ADDR_W:0]   head_q;
  logic [ADDR_W:0]   wdata;

  assign wdata = {cmd_i.seq, cmd_i.dest};

  // Pointer and full flag update
  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    full_d = full_q;
    if (cmd_i.push) begin
      wr_d = (wr_q == LastSlot) ? '0 : wr_q + 1'b1;
      if (wr_d == rd_q) begin
        full_d = 1'b1;
      end
    end
    if (cmd_i.pop) begin
      rd_d   = (rd_q == LastSlot) ? '0 : rd_q + 1'b1;
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      full_q <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      full_q <= full_d;
    end
  end

  // Slot memory; the head register follows the next read pointer,
  // taking the word being written when it lands on that slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[wr_q] <= wdata;
    end
    if (cmd_i.push && (wr_q == rd_d)) begin
      head_q <= wdata;
    end else begin
      head_q <= mem_q[rd_d];
    end
  end

  assign stat_o.full      = full_q;
  assign stat_o.empty     = (wr_q == rd_q) && !full_q;
  assign stat_o.head_dest = head_q[ADDR_W-1:0];
  assign stat_o.head_seq  = head_q[ADDR_W];
  assign wr_ptr_o         = wr_q;
  assign rd_ptr_o         = rd_q;

endmodule

[sv/rlsw_dec.sv]
// Event decoder: builds the result word and the ring request for one word.
module rlsw_dec #(
  parameter int unsigned RingSlots = rlsw_pkg::RING_SLOTS_DEF,
  localparam int unsigned PtrW     = (RingSlots > 1) ? $clog2(RingSlots) : 1
) (
  input  rlsw_pkg::in_word_t    word_i,
  input  rlsw_pkg::cfg_t        cfg_i,
  input  logic                  exp_seq_i,
  input  rlsw_pkg::ring_stat_t  stat_i,
  input  logic [PtrW-1:0]       wr_ptr_i,
  input  logic [PtrW-1:0]       rd_ptr_i,
  output logic                  emit_o,
  output rlsw_pkg::out_word_t   res_o,
  output rlsw_pkg::ring_cmd_t   cmd_o,
  output logic                  toggle_o
);
  import rlsw_pkg::*;

  logic              for_us;
  logic              from_a, from_b;
  logic [SLOT_W-1:0] wr_slot, rd_slot;

  assign for_us  = (word_i.frame_dest == cfg_i.node_address);
  assign from_a  = (word_i.frame_src == cfg_i.neighbor_a);
  assign from_b  = (word_i.frame_src == cfg_i.neighbor_b);
  assign wr_slot = slot_field(ADDR_W'(wr_ptr_i));
  assign rd_slot = slot_field(ADDR_W'(rd_ptr_i));

  always_comb begin
    emit_o          = 1'b0;
    toggle_o        = 1'b0;
    cmd_o           = '0;
    res_o           = '0;
    res_o.hdr_src   = cfg_i.node_address;
    case (word_i.func)
      // CTS back to the sender, reporting ring state
      FUNC_RTS: begin
        emit_o            = 1'b1;
        res_o.result_kind = RK_CTS;
        res_o.hdr_type    = FT_CTS;
        res_o.hdr_dest    = word_i.frame_src;
        res_o.busy_flag   = stat_i.full;
        res_o.slot        = wr_slot;
      end
      // Data header: check sequence bit, readdress and queue
      FUNC_DATA: begin
        if (word_i.frame_type == FT_PAY && for_us) begin
          emit_o            = 1'b1;
          res_o.result_kind = RK_ACK;
          res_o.hdr_type    = FT_ACK;
          res_o.hdr_dest    = word_i.frame_src;
          if (word_i.frame_seq == exp_seq_i) begin
            toggle_o = 1'b1;
            if ((from_a || from_b) && !stat_i.full) begin
              cmd_o.push   = 1'b1;
              cmd_o.dest   = from_a ? cfg_i.neighbor_b : cfg_i.neighbor_a;
              cmd_o.seq    = word_i.frame_seq;
              res_o.slot   = wr_slot;
              res_o.stored = 1'b1;
            end
          end
        end
      end
      // Oldest descriptor out for transmit
      FUNC_SEND: begin
        if (!stat_i.empty) begin
          emit_o            = 1'b1;
          res_o.result_kind = RK_DESC;
          res_o.hdr_type    = FT_PAY;
          res_o.hdr_dest    = stat_i.head_dest;
          res_o.seq_bit     = stat_i.head_seq;
          res_o.slot        = rd_slot;
        end
      end
      // ACK or delivery done: release the oldest slot
      FUNC_ACK, FUNC_DONE: begin
        if (!stat_i.empty &&
            (word_i.func == FUNC_DONE || (word_i.frame_type == FT_ACK && for_us))) begin
          emit_o            = 1'b1;
          cmd_o.pop         = 1'b1;
          res_o.result_kind = RK_REL;
          res_o.hdr_type    = FT_NONE;
          res_o.hdr_dest    = stat_i.head_dest;
          res_o.seq_bit     = stat_i.head_seq;
          res_o.slot        = rd_slot;
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/relay_link_stop_and_wait.sv]
// Top level of the relay link layer: input stage, decoder, ring, result stage.
//
//  channel | direction | handshake               | payload
//  in      | into      | in_valid_i / in_ready_o  | in_word_i  (in_word_t)
//  out     | out of    | out_valid_o / out_ready_i| out_word_o (out_word_t)
//  cfg     | into      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One word per cycle while the output is not stalled: a word is held in the input
// stage, is decoded against the ring and sequence state, and its result, if one is
// emitted, lands in the output register that drives out_valid_o.
// The ring head is read through a registered memory port kept on the read pointer.
// Reset clears pointers, full flag, expected bit, valid flags and config registers; no clearing pass.
// A stalled output holds the input stage; in_ready_o drops only then.
module relay_link_stop_and_wait #(
  parameter int unsigned RING_SLOTS = rlsw_pkg::RING_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rlsw_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rlsw_pkg::out_word_t            out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rlsw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rlsw_pkg::ADDR_W-1:0]    cfg_data_i
);
  import rlsw_pkg::*;
  `include "relay_link_stop_and_wait_macros.svh"

  localparam int unsigned PtrW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  cfg_t       cfg;
  in_word_t   s1_word_q;
  logic       s1_valid_q;
  out_word_t  out_word_q, res;
  logic       out_valid_q;
  logic       exp_seq_q;
  logic       adv, emit, toggle;
  ring_cmd_t  dec_cmd, ring_cmd;
  ring_stat_t stat;
  logic [PtrW-1:0] wr_ptr, rd_ptr;

  rlsw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Decode stage moves when the result register is free or being drained
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_comb begin
    ring_cmd = dec_cmd;
    if (!adv) begin
      ring_cmd.push = 1'b0;
      ring_cmd.pop  = 1'b0;
    end
  end

  rlsw_dec #(.RingSlots(RING_SLOTS)) u_dec (
    .word_i    (s1_word_q),
    .cfg_i     (cfg),
    .exp_seq_i (exp_seq_q),
    .stat_i    (stat),
    .wr_ptr_i  (wr_ptr),
    .rd_ptr_i  (rd_ptr),
    .emit_o    (emit),
    .res_o     (res),
    .cmd_o     (dec_cmd),
    .toggle_o  (toggle)
  );

  rlsw_ring #(.RingSlots(RING_SLOTS)) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (ring_cmd),
    .stat_o   (stat),
    .wr_ptr_o (wr_ptr),
    .rd_ptr_o (rd_ptr)
  );

  // Input stage and expected sequence bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      exp_seq_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv && toggle) begin
        exp_seq_q <= !exp_seq_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Checks
  `RLSW_ASSERT_IMP(a_full_ptrs, clk_i, rst_ni, stat.full, wr_ptr == rd_ptr,
    "ring full while pointers differ")
  `RLSW_ASSERT_IMP(a_no_push_pop, clk_i, rst_ni, ring_cmd.push, !ring_cmd.pop,
    "push and pop in the same cycle")
  `RLSW_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_o,
    s1_valid_q && out_valid_q && !out_ready_i, "input stalled without output stall")
  `RLSW_ASSERT_NEXT(a_push_not_empty, clk_i, rst_ni, ring_cmd.push, !stat.empty,
    "ring empty after a push")

endmodule
